### hw/rtl/edge_adaptive_symmetric_fir_line_defines.svh
// Assertion macros for the edge-adaptive FIR line filter.
// Clocked on clk, disabled while rst is high; no other dependencies.
`ifndef EDGE_ADAPTIVE_SYMMETRIC_FIR_LINE_DEFINES_SVH
`define EDGE_ADAPTIVE_SYMMETRIC_FIR_LINE_DEFINES_SVH

// Immediate implication: cons holds in the cycle ante holds.
`define EAFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: cons holds in the cycle after ante.
`define EAFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/eafl_pkg.sv
// Package for the edge-adaptive FIR line filter: sizes, fixed-point
// constants and configuration register codes. No dependencies.
package eafl_pkg;

  localparam int MAX_HALF_TAPS = 4;
  localparam int MAX_LINE      = 4096;

  localparam int PIX_W     = 8;
  localparam int POS_W     = $clog2(MAX_LINE);
  localparam int WIN_DEPTH = 2 * MAX_HALF_TAPS + 1;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int TAP_IDX_W = $clog2(2 * WIN_DEPTH);
  localparam int K_W       = $clog2(MAX_HALF_TAPS + 1);

  localparam int HT_W      = 3;
  localparam int N_SETS    = 5;
  localparam int N_COEF    = 5;
  localparam int COEF_W    = 12;
  localparam int SET_W     = N_COEF * COEF_W;
  localparam int CFG_IDX_W = 3;

  localparam int PSUM_W    = PIX_W + 2;
  localparam int PROD_W    = COEF_W + PSUM_W;
  localparam int ACC_W     = PROD_W + 3;

  localparam int FRAC_BITS  = 10;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
  localparam int PIX_MAX    = (1 << PIX_W) - 1;

  localparam logic [SET_W-1:0] COEF_RESET = SET_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_TAPS = 3'd0,
    CFG_COEF_0    = 3'd1,
    CFG_COEF_1    = 3'd2,
    CFG_COEF_2    = 3'd3,
    CFG_COEF_3    = 3'd4,
    CFG_COEF_4    = 3'd5
  } cfg_reg_t;

  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

### hw/rtl/edge_adaptive_symmetric_fir_line.sv
// Edge-adaptive symmetric FIR over one line of pixels (top level).
// Depends on eafl_pkg and edge_adaptive_symmetric_fir_line_defines.svh.
//
// In steady state, while out_stall is low, one pixel is taken and one
// filtered pixel leaves per clock; the result of a pixel comes half_taps
// pixels later (capped at 4), through the window, product and output
// registers. The pixel that ends a line (line_end, or the pixel at index
// MAX_LINE-1) releases up to half_taps+1 results; the input stalls
// while they drain, as the single tap-product stage makes one result per
// cycle if out_stall is low. Filter half-length shrinks to the distance
// from either line edge, so short lines are handled. Coefficients are
// signed 12-bit, 10 fraction bits; results are rounded half up and
// clipped to 0..255. Configuration is to be written only while the block
// is idle (the user's duty; not enforced); cfg_ready is always high.

`include "edge_adaptive_symmetric_fir_line_defines.svh"

module edge_adaptive_symmetric_fir_line
  import eafl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel,
  input  logic                 line_end,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     filtered,
  output logic                 line_done,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SET_W-1:0]     cfg_data
);

  // configuration
  logic [HT_W-1:0]  half_taps;
  logic [SET_W-1:0] coef_set [N_SETS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_taps <= '0;
      for (int s = 0; s < N_SETS; s++) begin
        coef_set[s] <= COEF_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_HALF_TAPS: half_taps   <= cfg_data[HT_W-1:0];
        CFG_COEF_0:    coef_set[0] <= cfg_data;
        CFG_COEF_1:    coef_set[1] <= cfg_data;
        CFG_COEF_2:    coef_set[2] <= cfg_data;
        CFG_COEF_3:    coef_set[3] <= cfg_data;
        CFG_COEF_4:    coef_set[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // line state and window
  logic [PIX_W-1:0] window [WIN_DEPTH];
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] emitted;
  logic [POS_W-1:0] gp;
  logic             gend;
  logic [K_W-1:0]   gt;
  logic             gvalid;

  logic             in_fire;
  logic             item_end;
  logic [K_W-1:0]   t_cur;

  logic             pending;
  logic             last_emit;
  logic             emit_now;
  logic             s1_ready;

  logic [POS_W:0]   emitted_x;
  logic [POS_W:0]   emitted_inc;
  logic [POS_W:0]   gp_x;

  assign t_cur = (half_taps > HT_W'(MAX_HALF_TAPS)) ? K_W'(MAX_HALF_TAPS)
                                                    : K_W'(half_taps);
  assign item_end = line_end || (position >= POS_W'(MAX_LINE - 1));

  assign emitted_x   = {1'b0, emitted};
  assign emitted_inc = emitted_x + (POS_W + 1)'(1);
  assign gp_x        = {1'b0, gp};

  assign pending = gvalid && (emitted_x <= gp_x) &&
                   (gend || (emitted_x + (POS_W + 1)'(gt) <= gp_x));
  assign last_emit = gend ? (emitted == gp)
                          : (emitted_inc + (POS_W + 1)'(gt) > gp_x);
  assign emit_now = pending && s1_ready;

  assign in_stall = pending && !(s1_ready && last_emit);
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      emitted  <= '0;
      gvalid   <= 1'b0;
    end else begin
      if (emit_now) begin
        emitted <= (gend && last_emit) ? '0 : emitted_inc[POS_W-1:0];
      end
      if (in_fire) begin
        gvalid   <= 1'b1;
        position <= item_end ? '0 : position + POS_W'(1);
      end else if (emit_now && gend && last_emit) begin
        gvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      gp        <= position;
      gend      <= item_end;
      gt        <= t_cur;
      window[0] <= pixel;
      for (int w = 1; w < WIN_DEPTH; w++) begin
        window[w] <= window[w-1];
      end
    end
  end

  // tap selection and products for output emitted
  logic [POS_W-1:0]     dist_full;
  logic [TAP_IDX_W-1:0] tap_back;
  logic [K_W-1:0]       k_sel;
  logic [K_W-1:0]       k_nt;
  prod_t                prod [N_COEF];

  function automatic logic [PIX_W-1:0] win_at(input logic [PIX_W-1:0] win [WIN_DEPTH],
                                               input logic [TAP_IDX_W-1:0] back);
    logic [PIX_W-1:0] v;
    v = '0;
    if (back < TAP_IDX_W'(WIN_DEPTH)) begin
      v = win[back[WIN_IDX_W-1:0]];
    end
    return v;
  endfunction

  assign dist_full = gp - emitted;
  assign tap_back  = dist_full[TAP_IDX_W-1:0];

  always_comb begin
    k_nt  = (emitted < POS_W'(gt)) ? K_W'(emitted) : gt;
    k_sel = (POS_W'(k_nt) < dist_full) ? k_nt : K_W'(dist_full);
  end

  always_comb begin
    logic signed [COEF_W-1:0] c;
    logic        [PSUM_W-1:0] psum;
    for (int i = 0; i < N_COEF; i++) begin
      c = coef_set[k_sel][i*COEF_W +: COEF_W];
      if (i == 0) begin
        psum = PSUM_W'(win_at(window, tap_back));
      end else if (K_W'(i) <= k_sel) begin
        psum = PSUM_W'(win_at(window, tap_back + TAP_IDX_W'(i))) +
               PSUM_W'(win_at(window, tap_back - TAP_IDX_W'(i)));
      end else begin
        psum = '0;
      end
      prod[i] = c * $signed(psum);
    end
  end

  // product register
  logic  s1_valid;
  logic  s1_done;
  prod_t s1_prod [N_COEF];
  logic  out_adv;

  assign out_adv  = !out_valid || !out_stall;
  assign s1_ready = !s1_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      s1_done <= gend && (emitted == gp);
      for (int i = 0; i < N_COEF; i++) begin
        s1_prod[i] <= prod[i];
      end
    end
  end

  // sum, round, clip
  logic signed [ACC_W-1:0] acc;
  logic        [PIX_W-1:0] y;

  always_comb begin
    acc = ACC_W'(ROUND_HALF);
    for (int i = 0; i < N_COEF; i++) begin
      acc = acc + ACC_W'(s1_prod[i]);
    end
    if (acc[ACC_W-1]) begin
      y = '0;
    end else if (acc[ACC_W-2:FRAC_BITS+PIX_W] != '0) begin
      y = PIX_W'(PIX_MAX);
    end else begin
      y = acc[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      filtered  <= y;
      line_done <= s1_done;
    end
  end

  // checks
  `EAFL_ASSERT_IMP(a_emit_bound, gvalid, emitted_x <= gp_x + (POS_W + 1)'(1), "emitted past item")
  `EAFL_ASSERT_IMP(a_backlog, pending, dist_full <= POS_W'(MAX_HALF_TAPS), "backlog beyond window")
  `EAFL_ASSERT_NXT(a_line_reset, emit_now && gend && last_emit, emitted == '0, "line not reset")

endmodule
